FILE: hdl/hid_report_rx_sync_deframer_top_assert.svh
// ----------------------------------------------------------------------------
// HID report deframer assertion macros
// Shared concurrent assertion forms for the deframer.
// ----------------------------------------------------------------------------
`ifndef HID_REPORT_RX_SYNC_DEFRAMER_TOP_ASSERT_SVH
`define HID_REPORT_RX_SYNC_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication
`define HRD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define HRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hdl/hrd_pkg.sv
// ----------------------------------------------------------------------------
// hrd_pkg
// Types and constants for the HID report deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package hrd_pkg;

   localparam int BYTE_W               = 8;
   localparam int SIZE_W               = 6;
   localparam int COUNT_W              = 7;
   localparam int NUM_SIZE_REGS        = 5;
   localparam int REG_IDX_W            = 3;
   localparam int CSR_ADDR_W           = 5;
   localparam int CSR_DATA_W           = 32;
   localparam int MAX_REPORT_BYTES_DEF = 64;
   localparam int OUTQ_DEPTH           = 4;
   localparam int OUTQ_PTR_W           = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_LVL_W           = $clog2(OUTQ_DEPTH + 1);

   localparam logic [BYTE_W-1:0] SYNC_BYTE      = 8'h55;
   localparam logic [BYTE_W-1:0] INJECT_BYTE    = 8'hFF;
   localparam logic [BYTE_W-1:0] FIRST_SIZED_ID = 8'd5;
   localparam logic [BYTE_W-1:0] LAST_SIZED_ID  = 8'd9;

   localparam logic [REG_IDX_W-1:0] REG_SIZE_REPORT5 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SIZE_REPORT6 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SIZE_REPORT7 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SIZE_REPORT8 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SIZE_REPORT9 = 3'd4;

   localparam logic [SIZE_W-1:0] SIZE_REPORT5_RST = 6'd8;
   localparam logic [SIZE_W-1:0] SIZE_REPORT6_RST = 6'd10;
   localparam logic [SIZE_W-1:0] SIZE_REPORT7_RST = 6'd14;
   localparam logic [SIZE_W-1:0] SIZE_REPORT8_RST = 6'd20;
   localparam logic [SIZE_W-1:0] SIZE_REPORT9_RST = 6'd63;

   typedef logic [NUM_SIZE_REGS-1:0][SIZE_W-1:0] size_array_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } entry_type;

   typedef struct packed {
      logic [1:0] num;
      entry_type  slot0;
      entry_type  slot1;
   } push_type;

   typedef struct packed {
      logic                  room;
      logic [OUTQ_LVL_W-1:0] level;
   } outq_status_type;

endpackage

`default_nettype wire

FILE: hdl/hrd_frame.sv
// ----------------------------------------------------------------------------
// hrd_frame
// Report framing, payload limit and sync search; emits zero to two words.
// ----------------------------------------------------------------------------
`default_nettype none

module hrd_frame #(
   parameter int MAX_REPORT_BYTES = hrd_pkg::MAX_REPORT_BYTES_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       fire,
   input  wire logic [hrd_pkg::BYTE_W-1:0] data_byte,
   input  wire logic                       last_in_report,
   input  wire hrd_pkg::size_array_type    size_regs,
   output      hrd_pkg::push_type          push
);

   localparam logic [hrd_pkg::COUNT_W-1:0] CAP = hrd_pkg::COUNT_W'(MAX_REPORT_BYTES - 1);

   logic                         at_start_ff, at_start_in;
   logic [hrd_pkg::COUNT_W-1:0]  limit_ff, limit_in;
   logic [hrd_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                         sync_ff, sync_in;
   logic [hrd_pkg::COUNT_W-1:0]  id_limit;
   logic [hrd_pkg::COUNT_W-1:0]  raw_limit;
   logic [hrd_pkg::REG_IDX_W-1:0] size_idx;
   logic                         sized_id;

   always_comb begin
      sized_id  = (data_byte >= hrd_pkg::FIRST_SIZED_ID) &&
                  (data_byte <= hrd_pkg::LAST_SIZED_ID);
      size_idx  = hrd_pkg::REG_IDX_W'(data_byte - hrd_pkg::FIRST_SIZED_ID);
      raw_limit = sized_id ? {1'b0, size_regs[size_idx]} : CAP;
      id_limit  = (raw_limit > CAP) ? CAP : raw_limit;
   end

   always_comb begin
      at_start_in = at_start_ff;
      limit_in    = limit_ff;
      count_in    = count_ff;
      sync_in     = sync_ff;
      push        = '0;
      if (fire) begin
         at_start_in = last_in_report;
         if (at_start_ff) begin
            limit_in = id_limit;
            count_in = '0;
            sync_in  = 1'b0;
         end else if (count_ff < limit_ff) begin
            count_in = count_ff + 1'b1;
            if (sync_ff) begin
               push.num        = 2'd1;
               push.slot0.data = data_byte;
               push.slot0.last = 1'b1;
            end else if (data_byte == hrd_pkg::SYNC_BYTE) begin
               sync_in         = 1'b1;
               push.num        = 2'd2;
               push.slot0.data = hrd_pkg::INJECT_BYTE;
               push.slot0.last = 1'b0;
               push.slot1.data = hrd_pkg::SYNC_BYTE;
               push.slot1.last = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
         limit_ff    <= '0;
         count_ff    <= '0;
         sync_ff     <= 1'b0;
      end else begin
         at_start_ff <= at_start_in;
         limit_ff    <= limit_in;
         count_ff    <= count_in;
         sync_ff     <= sync_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/hrd_outq.sv
// ----------------------------------------------------------------------------
// hrd_outq
// Small result queue; takes up to two words per cycle, gives one when ready.
// ----------------------------------------------------------------------------
`default_nettype none

module hrd_outq (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire hrd_pkg::push_type          push,
   output      logic                       out_valid,
   input  wire logic                       out_ready,
   output      hrd_pkg::entry_type         out_entry,
   output      hrd_pkg::outq_status_type   status
);

   hrd_pkg::entry_type                 mem_ff [hrd_pkg::OUTQ_DEPTH];
   logic [hrd_pkg::OUTQ_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [hrd_pkg::OUTQ_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [hrd_pkg::OUTQ_LVL_W-1:0]     level_ff, level_in;
   logic [hrd_pkg::OUTQ_PTR_W-1:0]     wr_ptr_next;
   logic                               pop;

   always_comb begin
      pop         = out_valid && out_ready;
      wr_ptr_next = wr_ptr_ff + 1'b1;
      wr_ptr_in   = wr_ptr_ff + hrd_pkg::OUTQ_PTR_W'(push.num);
      rd_ptr_in   = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in    = level_ff + hrd_pkg::OUTQ_LVL_W'(push.num)
                  - hrd_pkg::OUTQ_LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.slot0;
      end
      if (push.num == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.slot1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   assign out_valid    = (level_ff != '0);
   assign out_entry    = mem_ff[rd_ptr_ff];
   assign status.level = level_ff;
   assign status.room  = (level_ff <= hrd_pkg::OUTQ_LVL_W'(hrd_pkg::OUTQ_DEPTH - 2));

endmodule

`default_nettype wire

FILE: hdl/hid_report_rx_sync_deframer_top.sv
// ----------------------------------------------------------------------------
// hid_report_rx_sync_deframer_top
// HID output report deframer with sync byte reinsertion.
// A result word enters the registered result queue when its input word is
// taken. Throughput: one input word per cycle while the four-entry result
// queue has two entries free; a sync byte yields two words.
// Reset: synchronous, clears framing state and queue, size registers go to
// 8, 10, 14, 20 and 63; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hid_report_rx_sync_deframer_top_assert.svh"

module hid_report_rx_sync_deframer_top #(
   parameter int MAX_REPORT_BYTES = hrd_pkg::MAX_REPORT_BYTES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   input  wire logic [7:0]                     req_tdata,  // [7:0] data_byte
   input  wire logic                           req_tlast,  // last_in_report
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   output      logic [7:0]                     rsp_tdata,  // [7:0] out_byte
   output      logic                           rsp_tlast,  // last_of_run
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [hrd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [hrd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output      logic [hrd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output      logic                           csr_pready
);

   hrd_pkg::size_array_type          size_ff, size_in;
   logic [hrd_pkg::REG_IDX_W-1:0]    csr_idx;
   logic                             csr_wr;
   logic                             req_fire;
   hrd_pkg::push_type                push;
   hrd_pkg::entry_type               out_entry;
   hrd_pkg::outq_status_type         status;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[hrd_pkg::CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      size_in = size_ff;
      if (csr_wr) begin
         case (csr_idx)
            hrd_pkg::REG_SIZE_REPORT5: size_in[0] = csr_pwdata[hrd_pkg::SIZE_W-1:0];
            hrd_pkg::REG_SIZE_REPORT6: size_in[1] = csr_pwdata[hrd_pkg::SIZE_W-1:0];
            hrd_pkg::REG_SIZE_REPORT7: size_in[2] = csr_pwdata[hrd_pkg::SIZE_W-1:0];
            hrd_pkg::REG_SIZE_REPORT8: size_in[3] = csr_pwdata[hrd_pkg::SIZE_W-1:0];
            hrd_pkg::REG_SIZE_REPORT9: size_in[4] = csr_pwdata[hrd_pkg::SIZE_W-1:0];
            default: size_in = size_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         hrd_pkg::REG_SIZE_REPORT5: csr_prdata = hrd_pkg::CSR_DATA_W'(size_ff[0]);
         hrd_pkg::REG_SIZE_REPORT6: csr_prdata = hrd_pkg::CSR_DATA_W'(size_ff[1]);
         hrd_pkg::REG_SIZE_REPORT7: csr_prdata = hrd_pkg::CSR_DATA_W'(size_ff[2]);
         hrd_pkg::REG_SIZE_REPORT8: csr_prdata = hrd_pkg::CSR_DATA_W'(size_ff[3]);
         hrd_pkg::REG_SIZE_REPORT9: csr_prdata = hrd_pkg::CSR_DATA_W'(size_ff[4]);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff[0] <= hrd_pkg::SIZE_REPORT5_RST;
         size_ff[1] <= hrd_pkg::SIZE_REPORT6_RST;
         size_ff[2] <= hrd_pkg::SIZE_REPORT7_RST;
         size_ff[3] <= hrd_pkg::SIZE_REPORT8_RST;
         size_ff[4] <= hrd_pkg::SIZE_REPORT9_RST;
      end else begin
         size_ff <= size_in;
      end
   end

   assign req_tready = status.room;
   assign req_fire   = req_tvalid && req_tready;

   hrd_frame #(
      .MAX_REPORT_BYTES (MAX_REPORT_BYTES)
   ) u_frame (
      .clock          (clock),
      .reset          (reset),
      .fire           (req_fire),
      .data_byte      (req_tdata),
      .last_in_report (req_tlast),
      .size_regs      (size_ff),
      .push           (push)
   );

   hrd_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_entry (out_entry),
      .status    (status)
   );

   assign rsp_tdata = out_entry.data;
   assign rsp_tlast = out_entry.last;

   `HRD_ASSERT_IMPL(a_level_bound, clock, reset, 1'b1,
      status.level <= hrd_pkg::OUTQ_LVL_W'(hrd_pkg::OUTQ_DEPTH))
   `HRD_ASSERT_IMPL(a_accept_room, clock, reset, req_fire,
      status.level <= hrd_pkg::OUTQ_LVL_W'(hrd_pkg::OUTQ_DEPTH - 2))
   `HRD_ASSERT_IMPL(a_inject_pair, clock, reset, rsp_tvalid && !rsp_tlast,
      status.level >= hrd_pkg::OUTQ_LVL_W'(2) && rsp_tdata == hrd_pkg::INJECT_BYTE)
   `HRD_ASSERT_NEXT(a_inject_then_sync, clock, reset,
      rsp_tvalid && rsp_tready && !rsp_tlast,
      rsp_tvalid && rsp_tlast && rsp_tdata == hrd_pkg::SYNC_BYTE)

endmodule

`default_nettype wire

FILE: verif/tb_hid_report_rx_sync_deframer_top.sv
// ----------------------------------------------------------------------------
// tb_hid_report_rx_sync_deframer_top
// Self-checking bench for the HID report deframer. A directed table covers
// ID-only reports, sync insertion, payload past the limit and reports with no
// sync byte. Random report streams follow, run under several size register
// settings. Each word is checked against the table or a model of framing and
// sync logic, with random stalls on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_hid_report_rx_sync_deframer_top;

   localparam int ITEMS        = 850;
   localparam int PHASE_ITEMS  = 110;
   localparam int LIMIT_CYCLES = 400000;
   localparam int MAX_PAYLOAD  = hrd_pkg::MAX_REPORT_BYTES_DEF - 1;
   localparam int CSR_SLOTS    = 8;
   localparam int HOLD_CYCLES  = 300;

   localparam hrd_pkg::entry_type NO_WORD     = '0;
   localparam hrd_pkg::entry_type INJECT_WORD = '{hrd_pkg::INJECT_BYTE, 1'b0};
   localparam hrd_pkg::entry_type SYNC_WORD   = '{hrd_pkg::SYNC_BYTE, 1'b1};

   typedef struct packed {
      logic [7:0]         data;
      logic               last;
      logic               typed;
      logic [1:0]         n_words;
      hrd_pkg::entry_type w0;
      hrd_pkg::entry_type w1;
   } stim_row_type;

   localparam int NUM_ROWS = 21;
   localparam stim_row_type DIR_ROWS [NUM_ROWS] = '{
      '{8'h00, 1'b1, 1'b1, 2'd0, NO_WORD, NO_WORD},
      '{8'h05, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
      '{8'h00, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
      '{8'hFF, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
      '{8'h55, 1'b0, 1'b1, 2'd2, INJECT_WORD, SYNC_WORD},
      '{8'hAA, 1'b0, 1'b1, 2'd1, '{8'hAA, 1'b1}, NO_WORD},
      '{8'h55, 1'b0, 1'b1, 2'd1, SYNC_WORD, NO_WORD},
      '{8'h01, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{8'h80, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{8'h7F, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{8'h55, 1'b1, 1'b1, 2'd0, NO_WORD, NO_WORD},
      '{8'h0A, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{8'h55, 1'b1, 1'b1, 2'd2, INJECT_WORD, SYNC_WORD},
      '{8'h04, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{8'h12, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
      '{8'h55, 1'b0, 1'b1, 2'd2, INJECT_WORD, SYNC_WORD},
      '{8'hFF, 1'b1, 1'b1, 2'd1, '{8'hFF, 1'b1}, NO_WORD},
      '{8'h09, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
      '{8'h00, 1'b1, 1'b1, 2'd0, NO_WORD, NO_WORD},
      '{8'h08, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{8'h55, 1'b1, 1'b1, 2'd2, INJECT_WORD, SYNC_WORD}
   };

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           req_tvalid  = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata   = '0;
   logic                           req_tlast   = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready  = 1'b0;
   logic [7:0]                     rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [hrd_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [hrd_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [hrd_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   hid_report_rx_sync_deframer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // [7:0] data_byte
      .req_tlast   (req_tlast),   // last_in_report
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // [7:0] out_byte
      .rsp_tlast   (rsp_tlast),   // last_of_run
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // deframer model state
   logic [hrd_pkg::SIZE_W-1:0]  size_model [hrd_pkg::NUM_SIZE_REGS] = '{
      hrd_pkg::SIZE_REPORT5_RST, hrd_pkg::SIZE_REPORT6_RST,
      hrd_pkg::SIZE_REPORT7_RST, hrd_pkg::SIZE_REPORT8_RST,
      hrd_pkg::SIZE_REPORT9_RST};
   logic                        at_id         = 1'b1;
   logic [hrd_pkg::COUNT_W-1:0] payload_limit = '0;
   logic [hrd_pkg::COUNT_W-1:0] payload_count = '0;
   logic                        synced        = 1'b0;
   hrd_pkg::entry_type          out_pair [2];

   hrd_pkg::entry_type expected_out_words [$];
   int        error_count   = 0;
   int        total_items   = 0;
   int        cycle_count   = 0;
   int        hold_request  = 0;
   int        hold_left     = 0;
   bit        no_idle       = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int deframe_byte(input logic [7:0] b, input logic last);
      int n;
      logic [hrd_pkg::COUNT_W-1:0] lim;
      n = 0;
      if (at_id) begin
         lim = hrd_pkg::COUNT_W'(MAX_PAYLOAD);
         if (b >= hrd_pkg::FIRST_SIZED_ID && b <= hrd_pkg::LAST_SIZED_ID)
            lim = hrd_pkg::COUNT_W'(size_model[int'(b - hrd_pkg::FIRST_SIZED_ID)]);
         if (lim > hrd_pkg::COUNT_W'(MAX_PAYLOAD))
            lim = hrd_pkg::COUNT_W'(MAX_PAYLOAD);
         payload_limit = lim;
         payload_count = '0;
         synced = 1'b0;
      end else if (payload_count < payload_limit) begin
         payload_count = payload_count + 1'b1;
         if (synced) begin
            out_pair[0] = '{b, 1'b1};
            n = 1;
         end else if (b == hrd_pkg::SYNC_BYTE) begin
            synced = 1'b1;
            out_pair[0] = INJECT_WORD;
            out_pair[1] = SYNC_WORD;
            n = 2;
         end
      end
      at_id = last;
      return n;
   endfunction

   // result side: check each accepted word, then pick the next tready
   always @(posedge clock) begin
      hrd_pkg::entry_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_out_words.size() == 0) begin
            $error("unexpected word: out_byte %h last_of_run %b", rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = expected_out_words.pop_front();
            if (rsp_tdata !== want.data) begin
               $error("out_byte mismatch: expected %h, got %h", want.data, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_of_run mismatch: expected %b, got %b", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_request > 0) begin
         hold_left = hold_request - 1;
         hold_request = 0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= 11);
      end
   end

   task automatic send_word(input logic [7:0] b, input logic last, input logic typed,
                            input logic [1:0] n_typed, input hrd_pkg::entry_type t0,
                            input hrd_pkg::entry_type t1);
      int n;
      if (!no_idle && $urandom_range(99) < 11) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      total_items++;
      n = deframe_byte(b, last);
      if (typed) begin
         if (n_typed > 0) expected_out_words.push_back(t0);
         if (n_typed > 1) expected_out_words.push_back(t1);
      end else begin
         for (int i = 0; i < n; i++) expected_out_words.push_back(out_pair[i]);
      end
   endtask

   task automatic send_report();
      logic [7:0] id;
      logic [7:0] b;
      int lim;
      int plen;
      int sync_at;
      int r;
      bit well_formed;
      id = ($urandom_range(99) < 60) ? 8'($urandom_range(9, 5)) : 8'($urandom_range(255));
      lim = (id >= hrd_pkg::FIRST_SIZED_ID && id <= hrd_pkg::LAST_SIZED_ID) ?
            int'(size_model[int'(id - hrd_pkg::FIRST_SIZED_ID)]) : MAX_PAYLOAD;
      r = $urandom_range(99);
      if (r < 12)
         plen = 0;
      else if (r < 22)
         plen = $urandom_range(70, 1);
      else
         plen = $urandom_range(lim + 2, 1);
      well_formed = $urandom_range(99) < 75;
      sync_at = (plen > 0) ? $urandom_range((plen < 4) ? plen - 1 : 3, 0) : 0;
      send_word(id, plen == 0, 1'b0, 2'd0, NO_WORD, NO_WORD);
      for (int i = 0; i < plen; i++) begin
         b = 8'($urandom_range(255));
         if (well_formed) begin
            if (i == sync_at)
               b = hrd_pkg::SYNC_BYTE;
            else if (i < sync_at && b == hrd_pkg::SYNC_BYTE)
               b = ~b;
         end
         send_word(b, i == plen - 1, 1'b0, 2'd0, NO_WORD, NO_WORD);
      end
   endtask

   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      while (expected_out_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input int idx, input logic wr, input logic [31:0] val,
                             output logic [31:0] rd);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= hrd_pkg::CSR_ADDR_W'(idx * 4);
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      if (wr && idx < hrd_pkg::NUM_SIZE_REGS)
         size_model[idx] = val[hrd_pkg::SIZE_W-1:0];
   endtask

   task automatic csr_check(input int idx);
      logic [31:0] rd;
      csr_access(idx, 1'b0, '0, rd);
      if (rd[hrd_pkg::SIZE_W-1:0] !== size_model[idx]) begin
         $error("size_report%0d mismatch: expected %0d, got %0d",
                idx + hrd_pkg::FIRST_SIZED_ID, size_model[idx],
                rd[hrd_pkg::SIZE_W-1:0]);
         error_count++;
      end
   endtask

   function automatic logic [hrd_pkg::SIZE_W-1:0] pick_size(input int phase);
      case (phase)
         1: return '0;
         2: return '1;
         3: return hrd_pkg::SIZE_W'($urandom_range(2) == 0 ? 62 : $urandom_range(2, 1));
         default: begin
            case ($urandom_range(5))
               0: return '0;
               1: return hrd_pkg::SIZE_W'(1);
               2: return hrd_pkg::SIZE_W'(62);
               3: return '1;
               4: return hrd_pkg::SIZE_W'($urandom_range(63));
               default: return hrd_pkg::SIZE_W'($urandom_range(12));
            endcase
         end
      endcase
   endfunction

   initial begin
      logic [31:0] rd;
      int phase;
      int start;
      bit hold_done;
      phase = 1;
      hold_done = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < hrd_pkg::NUM_SIZE_REGS; i++) csr_check(i);

      for (int i = 0; i < NUM_ROWS; i++)
         send_word(DIR_ROWS[i].data, DIR_ROWS[i].last, DIR_ROWS[i].typed,
                   DIR_ROWS[i].n_words, DIR_ROWS[i].w0, DIR_ROWS[i].w1);

      while (total_items < ITEMS) begin
         wait_results_done();
         no_idle = (phase == 3);
         for (int i = 0; i < hrd_pkg::NUM_SIZE_REGS; i++)
            csr_access(i, 1'b1, ($urandom() & ~32'h3F) | 32'(pick_size(phase)), rd);
         if (phase == 1) begin
            for (int i = hrd_pkg::NUM_SIZE_REGS; i < CSR_SLOTS; i++)
               csr_access(i, 1'b1, $urandom(), rd);
         end
         for (int i = 0; i < hrd_pkg::NUM_SIZE_REGS; i++) csr_check(i);
         start = total_items;
         while (total_items - start < PHASE_ITEMS && total_items < ITEMS) begin
            if (phase == 2 && !hold_done && total_items - start >= 20) begin
               hold_request = HOLD_CYCLES;
               hold_done = 1'b1;
            end
            send_report();
         end
         phase++;
      end

      wait_results_done();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
